// File: rtl/ccap_pkg.sv
// Shared types, constants, CRC step and microcode table for the command port.
`timescale 1ns / 1ps

package ccap_pkg;

    localparam int PACKET_BYTES     = 20;
    localparam int BODY_BYTES       = 16;
    localparam int ATTEN_COUNT_DEF  = 4;
    localparam int IDX_W            = 5;
    localparam int STEP_W           = 3;

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [31:0] LEVEL_RESET  = 32'd127;

    localparam logic [31:0] CMD_PING     = 32'd1;
    localparam logic [31:0] CMD_SET      = 32'd2;
    localparam logic [31:0] CMD_GET      = 32'd3;
    localparam logic [31:0] RSP_OK       = 32'd1;
    localparam logic [31:0] RSP_BAD_CRC  = 32'hFFFF_FFFE;
    localparam logic [31:0] RSP_UNKNOWN  = 32'hFFFF_FFFF;

    localparam logic [IDX_W-1:0] LAST_RX_POS   = IDX_W'(PACKET_BYTES - 1);
    localparam logic [IDX_W-1:0] LAST_BODY_IDX = IDX_W'(BODY_BYTES - 1);
    localparam logic [IDX_W-1:0] LAST_RSP_IDX  = IDX_W'(PACKET_BYTES - 1);

    // Branch conditions of a microcode word
    localparam logic [2:0] C_NEXT      = 3'd0;
    localparam logic [2:0] C_JUMP      = 3'd1;
    localparam logic [2:0] C_NOT_END   = 3'd2;
    localparam logic [2:0] C_NOT_WR    = 3'd3;
    localparam logic [2:0] C_BODY_MORE = 3'd4;
    localparam logic [2:0] C_RESP_MORE = 3'd5;

    // Program addresses
    localparam logic [STEP_W-1:0] S_ACCEPT = 3'd0;
    localparam logic [STEP_W-1:0] S_DECODE = 3'd1;
    localparam logic [STEP_W-1:0] S_WRITE  = 3'd2;
    localparam logic [STEP_W-1:0] S_CRC    = 3'd3;
    localparam logic [STEP_W-1:0] S_REWIND = 3'd4;
    localparam logic [STEP_W-1:0] S_EMIT   = 3'd5;
    localparam logic [STEP_W-1:0] S_DONE   = 3'd6;
    localparam logic [STEP_W-1:0] S_SPARE  = 3'd7;

    typedef struct packed {
        logic accept;
        logic decode;
        logic emit_wr;
        logic crc;
        logic clr_idx;
        logic emit_resp;
    } ctrl_t;

    typedef struct packed {
        logic pos_end;
        logic is_wr;
        logic body_more;
        logic resp_more;
        logic out_free;
    } stat_t;

    typedef struct packed {
        ctrl_t             act;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // CRC-16/XMODEM, one byte, MSB first
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '0;
        unique case (step)
            S_ACCEPT: begin w.act.accept = 1'b1;    w.cond = C_NOT_END;   w.target = S_ACCEPT; end
            S_DECODE: begin w.act.decode = 1'b1;    w.cond = C_NOT_WR;    w.target = S_CRC;    end
            S_WRITE:  begin w.act.emit_wr = 1'b1;   w.cond = C_NEXT;      w.target = S_CRC;    end
            S_CRC:    begin w.act.crc = 1'b1;       w.cond = C_BODY_MORE; w.target = S_CRC;    end
            S_REWIND: begin w.act.clr_idx = 1'b1;   w.cond = C_NEXT;      w.target = S_EMIT;   end
            S_EMIT:   begin w.act.emit_resp = 1'b1; w.cond = C_RESP_MORE; w.target = S_EMIT;   end
            S_DONE:   begin w.cond = C_JUMP;        w.target = S_ACCEPT;                       end
            S_SPARE:  begin w.cond = C_JUMP;        w.target = S_ACCEPT;                       end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/ccap_seq.sv
// Microcode sequencer: step counter, control ROM and branch logic.
`timescale 1ns / 1ps

module ccap_seq
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ccap_pkg::stat_t stat,
    output ccap_pkg::ctrl_t ctrl,
    output logic            in_stall
);
    import ccap_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic              go;
    logic              taken;

    assign word = ucode(step_reg);

    // a step holds until its handshake can complete
    assign go = (!word.act.accept || in_valid)
              && (!(word.act.emit_wr || word.act.emit_resp) || stat.out_free);

    always_comb
    begin
        unique case (word.cond)
            C_NEXT:      taken = 1'b0;
            C_JUMP:      taken = 1'b1;
            C_NOT_END:   taken = !stat.pos_end;
            C_NOT_WR:    taken = !stat.is_wr;
            C_BODY_MORE: taken = stat.body_more;
            C_RESP_MORE: taken = stat.resp_more;
            default:     taken = 1'b1;
        endcase
    end

    always_comb
    begin
        priority if (!go)
        begin
            step_next = step_reg;
        end
        else if (taken)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_ACCEPT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign ctrl     = go ? word.act : '0;
    assign in_stall = (step_reg != S_ACCEPT);

endmodule

// File: rtl/ccap_datapath.sv
// Datapath: packet store, CRC registers, attenuator levels, response and output register.
`timescale 1ns / 1ps

module ccap_datapath
#(
    parameter int ATTENUATOR_COUNT = ccap_pkg::ATTEN_COUNT_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  ccap_pkg::ctrl_t ctrl,
    output ccap_pkg::stat_t stat,
    input  logic [7:0]      rx_byte,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            kind,
    output logic [7:0]      tx_byte,
    output logic            last,
    output logic [7:0]      atten_address,
    output logic [7:0]      atten_value
);
    import ccap_pkg::*;

    localparam int LVL_W = (ATTENUATOR_COUNT > 1) ? $clog2(ATTENUATOR_COUNT) : 1;

    logic [IDX_W-1:0] pos_reg;
    logic [7:0]       store_reg [PACKET_BYTES];
    logic [15:0]      crc_reg;
    logic [15:0]      rcrc_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [31:0]      rcmd_reg;
    logic [31:0]      ra1_reg;
    logic [31:0]      level_reg [ATTENUATOR_COUNT];
    logic             out_valid_reg;

    logic [31:0]      cmd;
    logic [31:0]      a1;
    logic [31:0]      a2;
    logic [31:0]      chk;
    logic             crc_ok;
    logic             in_range;
    logic [LVL_W-1:0] lvl_idx;
    logic             set_ok;
    logic [31:0]      rcmd_next;
    logic [31:0]      ra1_next;
    logic [7:0]       rsp_byte;
    logic             load;

    assign cmd = {store_reg[3],  store_reg[2],  store_reg[1],  store_reg[0]};
    assign a1  = {store_reg[7],  store_reg[6],  store_reg[5],  store_reg[4]};
    assign a2  = {store_reg[11], store_reg[10], store_reg[9],  store_reg[8]};
    assign chk = {store_reg[19], store_reg[18], store_reg[17], store_reg[16]};

    assign crc_ok   = ({16'h0000, crc_reg} == chk);
    assign in_range = (a1 != 32'd0) && (a1 <= 32'(ATTENUATOR_COUNT));
    assign lvl_idx  = LVL_W'(a1 - 32'd1);
    assign set_ok   = crc_ok && (cmd == CMD_SET);

    always_comb
    begin
        ra1_next = 32'd0;
        priority if (!crc_ok)
        begin
            rcmd_next = RSP_BAD_CRC;
        end
        else if (cmd == CMD_PING || cmd == CMD_SET)
        begin
            rcmd_next = cmd;
            ra1_next  = RSP_OK;
        end
        else if (cmd == CMD_GET)
        begin
            rcmd_next = CMD_GET;
            if (in_range)
            begin
                ra1_next = level_reg[lvl_idx];
            end
        end
        else
        begin
            rcmd_next = RSP_UNKNOWN;
        end
    end

    // response packet: command, arg1, zeros, CRC in the low half of the checksum
    always_comb
    begin
        unique case (idx_reg)
            5'd0:    rsp_byte = rcmd_reg[7:0];
            5'd1:    rsp_byte = rcmd_reg[15:8];
            5'd2:    rsp_byte = rcmd_reg[23:16];
            5'd3:    rsp_byte = rcmd_reg[31:24];
            5'd4:    rsp_byte = ra1_reg[7:0];
            5'd5:    rsp_byte = ra1_reg[15:8];
            5'd6:    rsp_byte = ra1_reg[23:16];
            5'd7:    rsp_byte = ra1_reg[31:24];
            5'd16:   rsp_byte = rcrc_reg[7:0];
            5'd17:   rsp_byte = rcrc_reg[15:8];
            default: rsp_byte = 8'h00;
        endcase
    end

    assign load = ctrl.emit_wr || ctrl.emit_resp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ATTENUATOR_COUNT; i++)
            begin
                level_reg[i] <= LEVEL_RESET;
            end
        end
        else
        begin
            if (ctrl.accept)
            begin
                pos_reg <= (pos_reg == LAST_RX_POS) ? '0 : pos_reg + IDX_W'(1);
                if (pos_reg < IDX_W'(BODY_BYTES))
                begin
                    crc_reg <= crc_step(crc_reg, rx_byte);
                end
            end
            else if (ctrl.decode)
            begin
                crc_reg <= '0;
            end
            if (ctrl.decode && set_ok && in_range)
            begin
                level_reg[lvl_idx] <= a2;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            store_reg[pos_reg] <= rx_byte;
        end
        if (ctrl.decode)
        begin
            rcmd_reg <= rcmd_next;
            ra1_reg  <= ra1_next;
            rcrc_reg <= '0;
        end
        else if (ctrl.crc)
        begin
            rcrc_reg <= crc_step(rcrc_reg, rsp_byte);
        end
        if (ctrl.decode || ctrl.clr_idx)
        begin
            idx_reg <= '0;
        end
        else if (ctrl.crc || ctrl.emit_resp)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (ctrl.emit_wr)
        begin
            kind          <= 1'b1;
            tx_byte       <= 8'h00;
            last          <= 1'b0;
            atten_address <= a1[7:0];
            atten_value   <= a2[7:0];
        end
        else if (ctrl.emit_resp)
        begin
            kind          <= 1'b0;
            tx_byte       <= rsp_byte;
            last          <= (idx_reg == LAST_RSP_IDX);
            atten_address <= 8'h00;
            atten_value   <= 8'h00;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stat.pos_end   = (pos_reg == LAST_RX_POS);
    assign stat.is_wr     = set_ok;
    assign stat.body_more = (idx_reg != LAST_BODY_IDX);
    assign stat.resp_more = (idx_reg != LAST_RSP_IDX);
    assign stat.out_free  = !out_valid_reg || !out_stall;

endmodule

// File: rtl/crc_checked_attenuator_command_port_core.sv
// Top level of the CRC-checked attenuator command port.
`timescale 1ns / 1ps

// Takes command bytes one per request and frames them into 20-byte little-endian
// packets (command, arg1..arg3, checksum); there is no resynchronization. A byte
// that does not end a packet is taken without a stall. The byte that ends a packet
// starts the microcode program, and rx requests stall until it returns: decode,
// an attenuator write result for a good set command, the response CRC at one
// byte per cycle over 16 response body bytes, one rewind step, 20 response bytes
// and a return step; the write result and response bytes also wait while the
// output side stalls. Results leave through a single output register, so one
// result can wait on the output while the sequencer prepares the next.
module crc_checked_attenuator_command_port_core
#(
    parameter int ATTENUATOR_COUNT = ccap_pkg::ATTEN_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] tx_byte,
    output logic       last,
    output logic [7:0] atten_address,
    output logic [7:0] atten_value
);
    import ccap_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    ccap_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctrl     (ctrl),
        .in_stall (in_stall)
    );

    ccap_datapath
    #(
        .ATTENUATOR_COUNT (ATTENUATOR_COUNT)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .tx_byte       (tx_byte),
        .last          (last),
        .atten_address (atten_address),
        .atten_value   (atten_value)
    );

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the CRC-checked attenuator command port.
`timescale 1ns / 1ps

module tb;
    import ccap_pkg::*;

    typedef enum logic [1:0] {CHK_GOOD, CHK_FLIP, CHK_HIGH, CHK_GIVEN} chk_mode_t;
    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_HEAVY} stall_mode_t;

    // one command packet; want_* is the typed response where the row has one
    typedef struct packed {
        logic [31:0] cmd;
        logic [31:0] arg1;
        logic [31:0] arg2;
        logic [31:0] arg3;
        chk_mode_t   chk;
        logic [31:0] chk_word;
        logic        typed;
        logic [31:0] want_cmd;
        logic [31:0] want_arg;
    } cmd_row_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic [7:0] atten_address;
        logic [7:0] atten_value;
    } port_result_t;

    localparam int DIRECTED_ROWS = 16;
    localparam int RANDOM_PACKETS = 4;

    localparam cmd_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{32'h0, 32'h0, 32'h0, 32'h0, CHK_GIVEN, 32'h0, 1'b1, RSP_UNKNOWN, 32'h0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          CHK_GIVEN, 32'hFFFF_FFFF, 1'b1, RSP_BAD_CRC, 32'h0},
        '{CMD_PING, 32'h0, 32'h0, 32'h0, CHK_GOOD, 32'h0, 1'b1, RSP_OK, RSP_OK},
        '{CMD_GET, 32'd1, 32'h0, 32'h0, CHK_GOOD, 32'h0, 1'b1, CMD_GET, LEVEL_RESET},
        '{CMD_SET, 32'd1, 32'hFFFF_FFFF, 32'hA5A5_5A5A, CHK_GOOD, 32'h0,
          1'b1, CMD_SET, RSP_OK},
        '{CMD_GET, 32'd1, 32'h0, 32'h0, CHK_GOOD, 32'h0, 1'b0, 32'h0, 32'h0},
        '{CMD_SET, 32'd4, 32'h0, 32'h0, CHK_GOOD, 32'h0, 1'b1, CMD_SET, RSP_OK},
        '{CMD_SET, 32'd0, 32'd55, 32'h0, CHK_GOOD, 32'h0, 1'b1, CMD_SET, RSP_OK},
        '{CMD_SET, 32'h0000_0101, 32'h0000_00C3, 32'h0, CHK_GOOD, 32'h0,
          1'b1, CMD_SET, RSP_OK},
        '{CMD_GET, 32'd0, 32'h0, 32'h0, CHK_GOOD, 32'h0, 1'b1, CMD_GET, 32'h0},
        '{CMD_GET, 32'hFFFF_FFFF, 32'h0, 32'h0, CHK_GOOD, 32'h0, 1'b1, CMD_GET, 32'h0},
        '{CMD_PING, 32'h0, 32'h0, 32'h0, CHK_HIGH, 32'h0, 1'b1, RSP_BAD_CRC, 32'h0},
        '{CMD_SET, 32'd2, 32'd9, 32'h0, CHK_FLIP, 32'h0, 1'b1, RSP_BAD_CRC, 32'h0},
        '{CMD_GET, 32'd2, 32'h0, 32'h0, CHK_GOOD, 32'h0, 1'b1, CMD_GET, LEVEL_RESET},
        '{32'h0000_0100, 32'd1, 32'h0, 32'h0, CHK_GOOD, 32'h0, 1'b1, RSP_UNKNOWN, 32'h0},
        '{CMD_GET, 32'd4, 32'h0, 32'h0, CHK_GOOD, 32'h0, 1'b0, 32'h0, 32'h0}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [7:0] atten_address;
    logic [7:0] atten_value;

    // predictor state
    int          rx_pos = 0;
    logic [7:0]  pkt_bytes [PACKET_BYTES];
    logic [15:0] rx_crc = 16'h0;
    logic [31:0] atten_level [ATTEN_COUNT_DEF];
    logic        want_typed = 1'b0;
    logic [31:0] want_cmd = 32'h0;
    logic [31:0] want_arg = 32'h0;

    port_result_t expected_results [$];
    int fail_count = 0;
    int burst_left = 0;

    stall_mode_t stall_mode = RX_OPEN;
    int          stall_tick = 0;

    crc_checked_attenuator_command_port_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .tx_byte       (tx_byte),
        .last          (last),
        .atten_address (atten_address),
        .atten_value   (atten_value)
    );

    always #1 clk = ~clk;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        repeat (8)
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        return c;
    endfunction

    function automatic logic [31:0] word_at(input int w);
        return {pkt_bytes[4*w+3], pkt_bytes[4*w+2], pkt_bytes[4*w+1], pkt_bytes[4*w]};
    endfunction

    // Advance the command decoder by one received byte; queue what it answers.
    task automatic take_rx_byte(input logic [7:0] b);
        logic [31:0]  cmd;
        logic [31:0]  a1;
        logic [31:0]  a2;
        logic [31:0]  rsp_cmd;
        logic [31:0]  rsp_arg;
        logic [15:0]  rsp_crc;
        logic [7:0]   rsp [PACKET_BYTES];
        port_result_t res;
        pkt_bytes[rx_pos] = b;
        if (rx_pos < BODY_BYTES)
            rx_crc = crc_byte(rx_crc, b);
        if (rx_pos != PACKET_BYTES - 1)
        begin
            rx_pos++;
            return;
        end
        rx_pos = 0;
        cmd = word_at(0);
        a1  = word_at(1);
        a2  = word_at(2);
        rsp_arg = 32'h0;
        if ({16'h0, rx_crc} != word_at(4))
            rsp_cmd = RSP_BAD_CRC;
        else if (cmd == CMD_PING)
        begin
            rsp_cmd = RSP_OK;
            rsp_arg = RSP_OK;
        end
        else if (cmd == CMD_SET)
        begin
            rsp_cmd = CMD_SET;
            rsp_arg = RSP_OK;
            if (a1 >= 1 && a1 <= ATTEN_COUNT_DEF)
                atten_level[a1 - 1] = a2;
            res = '0;
            res.kind = 1'b1;
            res.atten_address = a1[7:0];
            res.atten_value = a2[7:0];
            expected_results.push_back(res);
        end
        else if (cmd == CMD_GET)
        begin
            rsp_cmd = CMD_GET;
            if (a1 >= 1 && a1 <= ATTEN_COUNT_DEF)
                rsp_arg = atten_level[a1 - 1];
        end
        else
            rsp_cmd = RSP_UNKNOWN;
        rx_crc = 16'h0;

        // typed rows override the computed answer (state update stays)
        if (want_typed)
        begin
            rsp_cmd = want_cmd;
            rsp_arg = want_arg;
        end
        for (int i = 0; i < PACKET_BYTES; i++)
            rsp[i] = 8'h00;
        for (int i = 0; i < 4; i++)
        begin
            rsp[i] = rsp_cmd[8*i +: 8];
            rsp[4+i] = rsp_arg[8*i +: 8];
        end
        rsp_crc = 16'h0;
        for (int i = 0; i < BODY_BYTES; i++)
            rsp_crc = crc_byte(rsp_crc, rsp[i]);
        rsp[16] = rsp_crc[7:0];
        rsp[17] = rsp_crc[15:8];
        for (int i = 0; i < PACKET_BYTES; i++)
        begin
            res = '0;
            res.tx_byte = rsp[i];
            res.last = (i == PACKET_BYTES - 1);
            expected_results.push_back(res);
        end
    endtask

    // Present one byte, hold it until taken, then maybe open a gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        rx_byte  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        take_rx_byte(b);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic send_packet(input cmd_row_t r);
        logic [7:0]  pkt [PACKET_BYTES];
        logic [15:0] body_crc;
        logic [31:0] chk;
        for (int i = 0; i < 4; i++)
        begin
            pkt[i]    = r.cmd[8*i +: 8];
            pkt[4+i]  = r.arg1[8*i +: 8];
            pkt[8+i]  = r.arg2[8*i +: 8];
            pkt[12+i] = r.arg3[8*i +: 8];
        end
        body_crc = 16'h0;
        for (int i = 0; i < BODY_BYTES; i++)
            body_crc = crc_byte(body_crc, pkt[i]);
        case (r.chk)
            CHK_GOOD: chk = {16'h0, body_crc};
            CHK_FLIP: chk = {16'h0, body_crc ^ 16'($urandom_range(1, 65535))};
            CHK_HIGH: chk = {16'($urandom_range(1, 65535)), body_crc};
            default:  chk = r.chk_word;
        endcase
        for (int i = 0; i < 4; i++)
            pkt[16+i] = chk[8*i +: 8];
        want_typed = r.typed;
        want_cmd   = r.want_cmd;
        want_arg   = r.want_arg;
        for (int i = 0; i < PACKET_BYTES; i++)
            send_byte(pkt[i]);
    endtask

    // receiver stall pattern: modes switch after a random hold time
    always @(posedge clk)
    begin
        if (stall_tick == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_tick <= $urandom_range(20, 120);
        end
        else
            stall_tick <= stall_tick - 1;
        case (stall_mode)
            RX_OPEN:     out_stall <= 1'b0;
            RX_RANDOM:   out_stall <= ($urandom_range(0, 99) < 35);
            RX_PERIODIC: out_stall <= (stall_tick % 4 == 0);
            default:     out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    always @(posedge clk)
    begin
        port_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result kind=%0d tx=%h last=%0d addr=%h val=%h",
                             $realtime, kind, tx_byte, last, atten_address, atten_value);
            end
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind || tx_byte !== want.tx_byte || last !== want.last ||
                    atten_address !== want.atten_address ||
                    atten_value !== want.atten_value)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch exp kind=%0d tx=%h last=%0d addr=%h val=%h, got kind=%0d tx=%h last=%0d addr=%h val=%h",
                                 $realtime, want.kind, want.tx_byte, want.last,
                                 want.atten_address, want.atten_value,
                                 kind, tx_byte, last, atten_address, atten_value);
                end
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        cmd_row_t r;
        int pick;
        for (int i = 0; i < ATTEN_COUNT_DEF; i++)
            atten_level[i] = LEVEL_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_packet(DIRECTED[i]);

        // mostly well-formed commands with random content, some broken or noise
        repeat (RANDOM_PACKETS)
        begin
            r = '0;
            r.arg1 = ($urandom_range(0, 4) == 0) ? $urandom
                                                 : $urandom_range(0, ATTEN_COUNT_DEF + 1);
            r.arg2 = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 255);
            r.arg3 = $urandom;
            r.chk = CHK_GOOD;
            pick = $urandom_range(0, 99);
            if (pick < 30)
                r.cmd = CMD_SET;
            else if (pick < 55)
                r.cmd = CMD_GET;
            else if (pick < 65)
                r.cmd = CMD_PING;
            else if (pick < 75)
                r.cmd = $urandom;
            else if (pick < 87)
            begin
                r.cmd = $urandom_range(CMD_PING, CMD_GET);
                r.chk = ($urandom_range(0, 1) == 0) ? CHK_FLIP : CHK_HIGH;
            end
            else
            begin
                r.cmd = $urandom;
                r.chk = CHK_GIVEN;
                r.chk_word = $urandom;
            end
            send_packet(r);
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: crc_checked_attenuator_command_port_core.f
rtl/ccap_pkg.sv
rtl/ccap_seq.sv
rtl/ccap_datapath.sv
rtl/crc_checked_attenuator_command_port_core.sv
tb/sv/tb.sv
